// File: rtl/ipv4_dotted_parse_classify_assert.svh
// ============================================================================
// ipv4_dotted_parse_classify_assert: assertion macros
// Shorthand for the concurrent checks of the IPv4 parser; clocked on clk and
// disabled while rst_n is low.
// ============================================================================
`ifndef IPV4_DOTTED_PARSE_CLASSIFY_ASSERT_SVH
`define IPV4_DOTTED_PARSE_CLASSIFY_ASSERT_SVH

// Same-cycle implication.
`define IPV4DP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IPV4DP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ipv4dp_pkg.sv
// ============================================================================
// ipv4dp_pkg: shared definitions for the IPv4 dotted-decimal parser
// Character codes, group limits, result layout and the special-block check.
// ============================================================================
`default_nettype none

package ipv4dp_pkg;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    localparam int unsigned GROUPS     = 4;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned ACC_W      = 12;
    localparam int unsigned TAIL_W     = 24;
    localparam int unsigned OUT_DATA_W = 40;

    localparam logic [CNT_W-1:0] MAX_GROUPS  = CNT_W'(GROUPS);
    localparam logic [CNT_W-1:0] LAST_GROUP  = CNT_W'(GROUPS - 1);
    localparam logic [ACC_W-1:0] GROUP_LIMIT = ACC_W'(255);

    // Parser state carried between characters.
    typedef struct packed {
        logic [7:0]        group_value;
        logic [CNT_W-1:0]  group_count;
        logic              want_digit;
        logic              parse_error;
        logic [TAIL_W-1:0] collected;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        group_value: 8'd0,
        group_count: '0,
        want_digit:  1'b1,
        parse_error: 1'b0,
        collected:   '0
    };

    function automatic logic special_block(input logic [31:0] a);
        logic [7:0] b0;
        logic [7:0] b1;
        logic       hit;
        b0  = a[31:24];
        b1  = a[23:16];
        hit = 1'b0;
        if (b0 == 8'd127) hit = 1'b1;
        if (b0 == 8'd10) hit = 1'b1;
        if (b0 == 8'd172 && b1 inside {[8'd16:8'd31]}) hit = 1'b1;
        if (b0 == 8'd192 && b1 == 8'd168) hit = 1'b1;
        if (b0 == 8'd169 && b1 == 8'd254) hit = 1'b1;
        if (b0 inside {[8'd224:8'd239]}) hit = 1'b1;
        if (a == 32'hFFFF_FFFF) hit = 1'b1;
        if (b0 == 8'd0) hit = 1'b1;
        return hit;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ipv4_dotted_parse_classify.sv
// ============================================================================
// ipv4_dotted_parse_classify: streaming dotted-decimal IPv4 parser/classifier
// Result: the result beat is registered when the held last char is consumed.
// Throughput: one character beat per cycle, but a last char waits while the result slot is full.
// Reset: rst_n (async, active low) clears the parser state and valid flags.
// ============================================================================
`default_nettype none

`include "ipv4_dotted_parse_classify_assert.svh"

module ipv4_dotted_parse_classify (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // character stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,   // last_char
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [ipv4dp_pkg::OUT_DATA_W-1:0] m_axis_tdata
    // m_axis_tdata: [0] addr_valid, [32:1] address, [33] special_range,
    //               [39:34] zero
);

    // ------------------------------------------------------------------
    // Input register: holds one character beat for the parse step.
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // Parser state and result register.
    ipv4dp_pkg::parse_state_t st_reg;
    ipv4dp_pkg::parse_state_t st_next;
    ipv4dp_pkg::parse_state_t st_step;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_ok_reg;
    logic [31:0] out_addr_reg;
    logic        out_special_reg;

    logic        out_free;
    logic        advance;
    logic        emit;

    logic        is_digit;
    logic        is_dot;
    logic [ipv4dp_pkg::ACC_W-1:0] acc;
    logic        res_ok;
    logic [31:0] res_addr;

    // The held beat moves on when it makes no result, or the result slot frees.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign emit          = advance && in_last_reg;
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Parse step: one character against the current state.
    // ------------------------------------------------------------------
    always_comb
    begin
        is_digit = in_char_reg inside {[ipv4dp_pkg::CHAR_ZERO:ipv4dp_pkg::CHAR_NINE]};
        is_dot   = (in_char_reg == ipv4dp_pkg::CHAR_DOT);
        // group * 10 + digit; '0'..'9' carry the digit in the low nibble
        acc = ({4'd0, st_reg.group_value} << 3) + ({4'd0, st_reg.group_value} << 1)
            + {8'd0, in_char_reg[3:0]};

        st_step = st_reg;
        if (!st_reg.parse_error)
        begin
            if (is_digit)
            begin
                if (st_reg.want_digit && st_reg.group_count >= ipv4dp_pkg::MAX_GROUPS)
                begin
                    st_step.parse_error = 1'b1;      // fifth group
                end
                else if (acc > ipv4dp_pkg::GROUP_LIMIT)
                begin
                    st_step.parse_error = 1'b1;      // group above 255
                end
                else
                begin
                    st_step.group_value = acc[7:0];
                    st_step.want_digit  = 1'b0;
                end
            end
            else if (is_dot)
            begin
                if (st_reg.want_digit)
                begin
                    st_step.parse_error = 1'b1;      // empty group
                end
                else
                begin
                    st_step.collected   = {st_reg.collected[ipv4dp_pkg::TAIL_W-9:0],
                                           st_reg.group_value};
                    st_step.group_count = st_reg.group_count + 1'b1;
                    st_step.group_value = 8'd0;
                    st_step.want_digit  = 1'b1;
                end
            end
            else
            begin
                st_step.parse_error = 1'b1;          // foreign character
            end
        end

        res_ok   = !st_step.parse_error && !st_step.want_digit
                   && (st_step.group_count == ipv4dp_pkg::LAST_GROUP);
        res_addr = res_ok ? {st_step.collected, st_step.group_value} : 32'd0;

        // Drop back to the start state once the final character is consumed.
        st_next = st_reg;
        if (advance)
        begin
            st_next = in_last_reg ? ipv4dp_pkg::STATE_RESET : st_step;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= ipv4dp_pkg::STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (emit)
        begin
            out_ok_reg      <= res_ok;
            out_addr_reg    <= res_addr;
            out_special_reg <= res_ok && ipv4dp_pkg::special_block(res_addr);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_special_reg, out_addr_reg, out_ok_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `IPV4DP_ASSERT_IMP(a_invalid_zero, m_axis_tvalid && !out_ok_reg,
        out_addr_reg == 32'd0 && !out_special_reg, "invalid result carries data")

    `IPV4DP_ASSERT_IMP(a_group_bound, 1'b1,
        st_reg.group_count <= ipv4dp_pkg::MAX_GROUPS, "group count past four")

    `IPV4DP_ASSERT_NEXT(a_clear_after_last, emit,
        st_reg.group_count == '0 && st_reg.want_digit && !st_reg.parse_error
        && st_reg.group_value == 8'd0 && m_axis_tvalid, "state not cleared after last")

    `IPV4DP_ASSERT_IMP(a_result_slot, in_valid_reg && in_last_reg && !out_free,
        !s_axis_tready, "final character passed a full result slot")

endmodule

`default_nettype wire
